// ----- rtl/bdhr_pkg.sv -----
// Shared types and constants for the button debounce, hold and repeat block.
package bdhr_pkg;

    localparam int TICK_W  = 32;
    localparam int LEVEL_W = 3;
    localparam int CFG_W   = 16;
    localparam int EVT_W   = 2;
    localparam int ADDR_W  = 2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd1000;
    localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd50;

    localparam logic [EVT_W-1:0] EVT_NONE = 2'd0;

    typedef enum logic [ADDR_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_HOLD     = 2'd1,
        REG_REPEAT   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] hold_ms;
        logic [CFG_W-1:0] repeat_ms;
    } t_cfg;

endpackage

// ----- rtl/bdhr_lane.sv -----
// Per-button lane: debounce, long-hold and repeat checks with the button's own state.
module bdhr_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bdhr_pkg::TICK_W-1:0] i_now,
    input  logic                        i_level,
    input  bdhr_pkg::t_cfg              i_cfg,
    input  logic                        i_commit,
    output logic                        o_fire
);
    import bdhr_pkg::*;

    logic              r_stable, n_stable;
    logic              r_held, n_held;
    logic [TICK_W-1:0] r_last, n_last;
    logic [TICK_W-1:0] r_press, n_press;
    logic [TICK_W-1:0] since_last;
    logic [TICK_W-1:0] since_press;

    assign since_last  = i_now - r_last;
    assign since_press = i_now - r_press;

    always_comb begin
        n_stable = r_stable;
        n_held   = r_held;
        n_last   = r_last;
        n_press  = r_press;
        o_fire   = 1'b0;
        if (i_level != r_stable) begin
            if (since_last > TICK_W'(i_cfg.debounce_ms)) begin
                n_last   = i_now;
                n_stable = i_level;
                n_held   = 1'b0;
                if (!i_level) begin
                    n_press = i_now;
                    o_fire  = 1'b1;
                end
            end
        end else if (!i_level) begin
            if (!r_held) begin
                if (since_press > TICK_W'(i_cfg.hold_ms)) begin
                    n_held = 1'b1;
                    n_last = i_now;
                    o_fire = 1'b1;
                end
            end else if (since_last > TICK_W'(i_cfg.repeat_ms)) begin
                n_last = i_now;
                o_fire = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_held   <= 1'b0;
            r_last   <= '0;
            r_press  <= '0;
        end else if (i_commit) begin
            r_stable <= n_stable;
            r_held   <= n_held;
            r_last   <= n_last;
            r_press  <= n_press;
        end
    end

endmodule

// ----- rtl/bdhr_merge.sv -----
// Priority merge: picks the first lane with an event and marks which lanes may update.
module bdhr_merge #(
    parameter int NUM_BUTTONS = 3
) (
    input  logic [NUM_BUTTONS-1:0]      i_fire,
    output logic [NUM_BUTTONS-1:0]      o_examine,
    output logic [bdhr_pkg::EVT_W-1:0]  o_code
);
    import bdhr_pkg::*;

    logic seen;

    always_comb begin
        seen   = 1'b0;
        o_code = EVT_NONE;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            o_examine[i] = ~seen;
            if (!seen && i_fire[i]) begin
                o_code = EVT_W'(i + 1);
            end
            seen = seen | i_fire[i];
        end
    end

endmodule

// ----- rtl/button_debounce_hold_repeat.sv -----
// Top level of the button debounce, long-hold and auto-repeat block.
//
// Input stream: each transaction is one poll. tdata carries the current
// 32-bit millisecond tick and the raw active-low levels of the middle, left
// and right buttons. Output stream: one transaction per poll, carrying the
// event code (0 none, 1 middle, 2 left, 3 right).
// Every button has its own lane that runs all checks in parallel; a priority
// merge reports the first lane with an event and lets only the lanes up to
// and including it update their state.
// The result is registered. Throughput is one poll per cycle while results
// are read, set by the single output register.
// A poll is accepted whenever the output register is empty or is being read
// in the same cycle, so a stalled receiver holds back the input after one
// result is waiting.
// Reset restores the timing registers to 20, 1000 and 50 ticks, marks every
// button released with zeroed times, and empties the output register.
// Configuration writes are taken at once while the block is idle.
module button_debounce_hold_repeat #(
    parameter int NUM_BUTTONS = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [31:0] now_ms, [34:32] button_levels, [39:35] zero
    input  logic [39:0]                 i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [1:0] event_button, [7:2] zero
    output logic [7:0]                  o_m_axis_tdata,
    input  logic                        i_cfg_we,
    input  logic [bdhr_pkg::ADDR_W-1:0] i_cfg_addr,
    input  logic [bdhr_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import bdhr_pkg::*;

    t_cfg              r_cfg;
    logic              r_out_valid;
    logic [EVT_W-1:0]  r_out_code;
    logic              accept;
    logic [TICK_W-1:0] now;
    logic [LEVEL_W-1:0] levels;
    logic [NUM_BUTTONS-1:0] fire;
    logic [NUM_BUTTONS-1:0] examine;
    logic [EVT_W-1:0]  code;

    assign now    = i_s_axis_tdata[TICK_W-1:0];
    assign levels = i_s_axis_tdata[TICK_W+LEVEL_W-1:TICK_W];

    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms <= DEBOUNCE_RST;
            r_cfg.hold_ms     <= HOLD_RST;
            r_cfg.repeat_ms   <= REPEAT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_DEBOUNCE: r_cfg.debounce_ms <= i_cfg_wdata;
                REG_HOLD:     r_cfg.hold_ms     <= i_cfg_wdata;
                REG_REPEAT:   r_cfg.repeat_ms   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic level;
        if (g < LEVEL_W) begin : g_wired
            assign level = levels[g];
        end else begin : g_absent
            assign level = 1'b1;
        end
        bdhr_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_now    (now),
            .i_level  (level),
            .i_cfg    (r_cfg),
            .i_commit (accept & examine[g]),
            .o_fire   (fire[g])
        );
    end

    bdhr_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_fire    (fire),
        .o_examine (examine),
        .o_code    (code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_code <= code;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(8-EVT_W){1'b0}}, r_out_code};

endmodule
